// ===== rtl/core/mips_decode_execute_unit_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef MIPS_DECODE_EXECUTE_UNIT_MACROS_SVH
`define MIPS_DECODE_EXECUTE_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define MDE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define MDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mde_pkg.sv =====
`timescale 1ns / 1ps

package mde_pkg;

	localparam logic [5:0] NO_REG = 6'd32;

	// Queue depth between front and back; keep a power of two so pointers wrap.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [4:0] {
		OP_ADD     = 5'd0,
		OP_ADDU    = 5'd1,
		OP_SUB     = 5'd2,
		OP_SUBU    = 5'd3,
		OP_ADDI    = 5'd4,
		OP_ADDIU   = 5'd5,
		OP_SLL     = 5'd6,
		OP_SRL     = 5'd7,
		OP_BEQ     = 5'd8,
		OP_BNE     = 5'd9,
		OP_J       = 5'd10,
		OP_JR      = 5'd11,
		OP_LUI     = 5'd12,
		OP_AND     = 5'd13,
		OP_OR      = 5'd14,
		OP_XOR     = 5'd15,
		OP_ANDI    = 5'd16,
		OP_ORI     = 5'd17,
		OP_XORI    = 5'd18,
		OP_LB      = 5'd19,
		OP_LH      = 5'd20,
		OP_LW      = 5'd21,
		OP_LBU     = 5'd22,
		OP_LHU     = 5'd23,
		OP_SB      = 5'd24,
		OP_SH      = 5'd25,
		OP_SW      = 5'd26,
		OP_UNKNOWN = 5'd27
	} op_t;

	typedef enum logic [3:0] {
		K_NONE     = 4'd0,
		K_R_ARITH  = 4'd1,
		K_R_SHIFT  = 4'd2,
		K_R_JUMP   = 4'd3,
		K_R_LOGIC  = 4'd4,
		K_I_ARITH  = 4'd5,
		K_I_LUI    = 4'd6,
		K_I_BRANCH = 4'd7,
		K_I_LOGIC  = 4'd8,
		K_I_LOAD   = 4'd9,
		K_I_STORE  = 4'd10,
		K_J_JUMP   = 4'd11
	} kind_t;

	// Classified instruction as it waits for the back end.
	typedef struct packed {
		op_t         op;
		kind_t       kind;
		logic        illegal;
		logic [5:0]  src1;
		logic [5:0]  src2;
		logic [5:0]  dst;
		logic [25:0] field;
		logic [31:0] pc;
		logic [31:0] rs_value;
		logic [31:0] rt_value;
	} dec_t;

endpackage

// ===== rtl/core/mips_decode_execute_unit.sv =====
`timescale 1ns / 1ps

// MIPS32 subset decode and execute stage.
// Input channel (in_valid/in_ready) carries one instruction word with its pc
// and the values of registers rs and rt. Output channel (out_valid/out_ready)
// carries one result item per instruction: decoded index, illegal flag,
// register numbers (32 means none), ALU result or store data, memory access
// and next pc. Results leave in the order the items came in.
// The accepting edge writes the decode queue, and the output register loads the
// queue head on a later edge, once that register is empty or being drained.
// Throughput: one item per cycle while out_ready stays high, limited by the
// single execute path that drains the queue head into the output register.
// The front classifies an item and writes it into a two-entry queue; in_ready
// is high while that queue has room, so it does not wait on out_ready.
// When the receiver stalls, the output register holds its item, the queue
// fills, and in_ready falls once both entries are taken.
// Reset (arst_n low) empties the queue and clears out_valid; no clearing pass.
module mips_decode_execute_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [31:0]  instr_word,
	input  logic [31:0]  pc,
	input  logic [31:0]  rs_value,
	input  logic [31:0]  rt_value,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [4:0]   op_index,
	output logic         illegal,
	output logic [5:0]   src1_reg,
	output logic [5:0]   src2_reg,
	output logic [5:0]   dst_reg,
	output logic [31:0]  result_value,
	output logic [31:0]  access_addr,
	output logic [2:0]   mem_bytes,
	output logic         is_load,
	output logic         is_store,
	output logic [31:0]  next_pc
);

	logic           push_valid;
	logic           push_ready;
	mde_pkg::dec_t  push_data;
	logic           pop_valid;
	logic           pop_ready;
	mde_pkg::dec_t  pop_data;

	mde_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.instr_word (instr_word),
		.pc         (pc),
		.rs_value   (rs_value),
		.rt_value   (rt_value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	mde_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	mde_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.op_index     (op_index),
		.illegal      (illegal),
		.src1_reg     (src1_reg),
		.src2_reg     (src2_reg),
		.dst_reg      (dst_reg),
		.result_value (result_value),
		.access_addr  (access_addr),
		.mem_bytes    (mem_bytes),
		.is_load      (is_load),
		.is_store     (is_store),
		.next_pc      (next_pc)
	);

endmodule

// ===== rtl/core/mde_front.sv =====
`timescale 1ns / 1ps

module mde_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        instr_word,
	input  logic [31:0]        pc,
	input  logic [31:0]        rs_value,
	input  logic [31:0]        rt_value,
	output logic               push_valid,
	input  logic               push_ready,
	output mde_pkg::dec_t      push_data
);

	localparam logic [5:0] OPC_SPECIAL = 6'h00;
	localparam logic [5:0] OPC_J       = 6'h02;
	localparam logic [5:0] OPC_BEQ     = 6'h04;
	localparam logic [5:0] OPC_BNE     = 6'h05;
	localparam logic [5:0] OPC_ADDI    = 6'h08;
	localparam logic [5:0] OPC_ADDIU   = 6'h09;
	localparam logic [5:0] OPC_ANDI    = 6'h0C;
	localparam logic [5:0] OPC_ORI     = 6'h0D;
	localparam logic [5:0] OPC_XORI    = 6'h0E;
	localparam logic [5:0] OPC_LUI     = 6'h0F;
	localparam logic [5:0] OPC_LB      = 6'h20;
	localparam logic [5:0] OPC_LH      = 6'h21;
	localparam logic [5:0] OPC_LW      = 6'h23;
	localparam logic [5:0] OPC_LBU     = 6'h24;
	localparam logic [5:0] OPC_LHU     = 6'h25;
	localparam logic [5:0] OPC_SB      = 6'h28;
	localparam logic [5:0] OPC_SH      = 6'h29;
	localparam logic [5:0] OPC_SW      = 6'h2B;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;

	logic [5:0]      opcode;
	logic [5:0]      funct;
	logic [5:0]      rs_num;
	logic [5:0]      rt_num;
	logic [5:0]      rd_num;
	mde_pkg::op_t    op;
	mde_pkg::kind_t  kind;
	logic [5:0]      src1;
	logic [5:0]      src2;
	logic [5:0]      dst;

	assign opcode = instr_word[31:26];
	assign funct  = instr_word[5:0];
	assign rs_num = {1'b0, instr_word[25:21]};
	assign rt_num = {1'b0, instr_word[20:16]};
	assign rd_num = {1'b0, instr_word[15:11]};

	always_comb begin
		op   = mde_pkg::OP_UNKNOWN;
		kind = mde_pkg::K_NONE;
		unique case (opcode)
			OPC_SPECIAL: begin
				unique case (funct)
					FN_ADD:  begin op = mde_pkg::OP_ADD;  kind = mde_pkg::K_R_ARITH; end
					FN_ADDU: begin op = mde_pkg::OP_ADDU; kind = mde_pkg::K_R_ARITH; end
					FN_SUB:  begin op = mde_pkg::OP_SUB;  kind = mde_pkg::K_R_ARITH; end
					FN_SUBU: begin op = mde_pkg::OP_SUBU; kind = mde_pkg::K_R_ARITH; end
					FN_SLL:  begin op = mde_pkg::OP_SLL;  kind = mde_pkg::K_R_SHIFT; end
					FN_SRL:  begin op = mde_pkg::OP_SRL;  kind = mde_pkg::K_R_SHIFT; end
					FN_JR:   begin op = mde_pkg::OP_JR;   kind = mde_pkg::K_R_JUMP;  end
					FN_AND:  begin op = mde_pkg::OP_AND;  kind = mde_pkg::K_R_LOGIC; end
					FN_OR:   begin op = mde_pkg::OP_OR;   kind = mde_pkg::K_R_LOGIC; end
					FN_XOR:  begin op = mde_pkg::OP_XOR;  kind = mde_pkg::K_R_LOGIC; end
					default: ;
				endcase
			end
			OPC_ADDI:  begin op = mde_pkg::OP_ADDI;  kind = mde_pkg::K_I_ARITH;  end
			OPC_ADDIU: begin op = mde_pkg::OP_ADDIU; kind = mde_pkg::K_I_ARITH;  end
			OPC_BEQ:   begin op = mde_pkg::OP_BEQ;   kind = mde_pkg::K_I_BRANCH; end
			OPC_BNE:   begin op = mde_pkg::OP_BNE;   kind = mde_pkg::K_I_BRANCH; end
			OPC_J:     begin op = mde_pkg::OP_J;     kind = mde_pkg::K_J_JUMP;   end
			OPC_LUI:   begin op = mde_pkg::OP_LUI;   kind = mde_pkg::K_I_LUI;    end
			OPC_ANDI:  begin op = mde_pkg::OP_ANDI;  kind = mde_pkg::K_I_LOGIC;  end
			OPC_ORI:   begin op = mde_pkg::OP_ORI;   kind = mde_pkg::K_I_LOGIC;  end
			OPC_XORI:  begin op = mde_pkg::OP_XORI;  kind = mde_pkg::K_I_LOGIC;  end
			OPC_LB:    begin op = mde_pkg::OP_LB;    kind = mde_pkg::K_I_LOAD;   end
			OPC_LH:    begin op = mde_pkg::OP_LH;    kind = mde_pkg::K_I_LOAD;   end
			OPC_LW:    begin op = mde_pkg::OP_LW;    kind = mde_pkg::K_I_LOAD;   end
			OPC_LBU:   begin op = mde_pkg::OP_LBU;   kind = mde_pkg::K_I_LOAD;   end
			OPC_LHU:   begin op = mde_pkg::OP_LHU;   kind = mde_pkg::K_I_LOAD;   end
			OPC_SB:    begin op = mde_pkg::OP_SB;    kind = mde_pkg::K_I_STORE;  end
			OPC_SH:    begin op = mde_pkg::OP_SH;    kind = mde_pkg::K_I_STORE;  end
			OPC_SW:    begin op = mde_pkg::OP_SW;    kind = mde_pkg::K_I_STORE;  end
			default: ;
		endcase
	end

	// Register usage follows the instruction format.
	always_comb begin
		src1 = mde_pkg::NO_REG;
		src2 = mde_pkg::NO_REG;
		dst  = mde_pkg::NO_REG;
		unique case (kind) inside
			mde_pkg::K_R_ARITH, mde_pkg::K_R_LOGIC: begin
				src1 = rs_num;
				src2 = rt_num;
				dst  = rd_num;
			end
			mde_pkg::K_R_SHIFT: begin
				src2 = rt_num;
				dst  = rd_num;
			end
			mde_pkg::K_R_JUMP: begin
				src1 = rs_num;
			end
			mde_pkg::K_I_ARITH, mde_pkg::K_I_LOGIC, mde_pkg::K_I_LOAD: begin
				src1 = rs_num;
				dst  = rt_num;
			end
			mde_pkg::K_I_LUI: begin
				dst = rt_num;
			end
			mde_pkg::K_I_BRANCH, mde_pkg::K_I_STORE: begin
				src1 = rs_num;
				src2 = rt_num;
			end
			default: ;
		endcase
	end

	assign push_valid         = in_valid;
	assign in_ready           = push_ready;
	assign push_data.op       = op;
	assign push_data.kind     = kind;
	assign push_data.illegal  = (op == mde_pkg::OP_UNKNOWN);
	assign push_data.src1     = src1;
	assign push_data.src2     = src2;
	assign push_data.dst      = dst;
	assign push_data.field    = instr_word[25:0];
	assign push_data.pc       = pc;
	assign push_data.rs_value = rs_value;
	assign push_data.rt_value = rt_value;

endmodule

// ===== rtl/core/mde_queue.sv =====
`timescale 1ns / 1ps

module mde_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  mde_pkg::dec_t  push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output mde_pkg::dec_t  pop_data
);

	mde_pkg::dec_t                     entry_q [mde_pkg::QDEPTH];
	logic [mde_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [mde_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [mde_pkg::QCNT_W-1:0]        count_q;
	logic                              push;
	logic                              pop;

	assign push_ready = (count_q != mde_pkg::QCNT_W'(mde_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/mde_back.sv =====
`timescale 1ns / 1ps

module mde_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  mde_pkg::dec_t  pop_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [4:0]     op_index,
	output logic           illegal,
	output logic [5:0]     src1_reg,
	output logic [5:0]     src2_reg,
	output logic [5:0]     dst_reg,
	output logic [31:0]    result_value,
	output logic [31:0]    access_addr,
	output logic [2:0]     mem_bytes,
	output logic           is_load,
	output logic           is_store,
	output logic [31:0]    next_pc
);

	localparam logic [2:0] BYTES_NONE = 3'd0;
	localparam logic [2:0] BYTES_BYTE = 3'd1;
	localparam logic [2:0] BYTES_HALF = 3'd2;
	localparam logic [2:0] BYTES_WORD = 3'd4;

	logic [15:0]  imm;
	logic [4:0]   shamt;
	logic [31:0]  simm;
	logic [31:0]  zimm;
	logic [31:0]  a;
	logic [31:0]  b;
	logic [31:0]  seq;
	logic [31:0]  res;
	logic [31:0]  addr;
	logic [2:0]   nbytes;
	logic         ld;
	logic         st;
	logic [31:0]  next;
	logic         advance;

	logic         out_valid_q;
	logic [4:0]   op_index_q;
	logic         illegal_q;
	logic [5:0]   src1_q;
	logic [5:0]   src2_q;
	logic [5:0]   dst_q;
	logic [31:0]  result_q;
	logic [31:0]  access_addr_q;
	logic [2:0]   mem_bytes_q;
	logic         is_load_q;
	logic         is_store_q;
	logic [31:0]  next_pc_q;

	assign imm   = pop_data.field[15:0];
	assign shamt = pop_data.field[10:6];
	assign simm  = {{16{imm[15]}}, imm};
	assign zimm  = {16'h0000, imm};
	assign a     = pop_data.rs_value;
	assign b     = pop_data.rt_value;
	assign seq   = pop_data.pc + 32'd4;

	always_comb begin
		res    = '0;
		addr   = '0;
		nbytes = BYTES_NONE;
		ld     = 1'b0;
		st     = 1'b0;
		next   = seq;
		unique case (pop_data.kind)
			mde_pkg::K_R_ARITH: begin
				if (pop_data.op == mde_pkg::OP_ADD || pop_data.op == mde_pkg::OP_ADDU) begin
					res = a + b;
				end else begin
					res = a - b;
				end
			end
			mde_pkg::K_R_LOGIC: begin
				if (pop_data.op == mde_pkg::OP_AND) begin
					res = a & b;
				end else if (pop_data.op == mde_pkg::OP_OR) begin
					res = a | b;
				end else begin
					res = a ^ b;
				end
			end
			mde_pkg::K_R_SHIFT: begin
				if (pop_data.op == mde_pkg::OP_SLL) begin
					res = b << shamt;
				end else begin
					res = b >> shamt;
				end
			end
			mde_pkg::K_R_JUMP: begin
				next = a;
			end
			mde_pkg::K_I_ARITH: begin
				res = a + simm;
			end
			mde_pkg::K_I_LOGIC: begin
				if (pop_data.op == mde_pkg::OP_ANDI) begin
					res = a & zimm;
				end else if (pop_data.op == mde_pkg::OP_ORI) begin
					res = a | zimm;
				end else begin
					res = a ^ zimm;
				end
			end
			mde_pkg::K_I_LUI: begin
				res = {imm, 16'h0000};
			end
			mde_pkg::K_I_BRANCH: begin
				// beq takes the branch on equal, bne on not equal
				if ((pop_data.op == mde_pkg::OP_BEQ) == (a == b)) begin
					next = seq + {simm[29:0], 2'b00};
				end
			end
			mde_pkg::K_J_JUMP: begin
				next = {seq[31:28], pop_data.field, 2'b00};
			end
			mde_pkg::K_I_LOAD: begin
				addr = a + simm;
				ld   = 1'b1;
				if (pop_data.op == mde_pkg::OP_LW) begin
					nbytes = BYTES_WORD;
				end else if (pop_data.op == mde_pkg::OP_LH || pop_data.op == mde_pkg::OP_LHU) begin
					nbytes = BYTES_HALF;
				end else begin
					nbytes = BYTES_BYTE;
				end
			end
			mde_pkg::K_I_STORE: begin
				addr = a + simm;
				st   = 1'b1;
				res  = b;
				if (pop_data.op == mde_pkg::OP_SW) begin
					nbytes = BYTES_WORD;
				end else if (pop_data.op == mde_pkg::OP_SH) begin
					nbytes = BYTES_HALF;
				end else begin
					nbytes = BYTES_BYTE;
				end
			end
			default: ;
		endcase
	end

	// Take the next item whenever the output register is empty or being drained.
	assign pop_ready = !out_valid_q || out_ready;
	assign advance   = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_index_q    <= pop_data.op;
			illegal_q     <= pop_data.illegal;
			src1_q        <= pop_data.src1;
			src2_q        <= pop_data.src2;
			dst_q         <= pop_data.dst;
			result_q      <= res;
			access_addr_q <= addr;
			mem_bytes_q   <= nbytes;
			is_load_q     <= ld;
			is_store_q    <= st;
			next_pc_q     <= next;
		end
	end

	assign out_valid    = out_valid_q;
	assign op_index     = op_index_q;
	assign illegal      = illegal_q;
	assign src1_reg     = src1_q;
	assign src2_reg     = src2_q;
	assign dst_reg      = dst_q;
	assign result_value = result_q;
	assign access_addr  = access_addr_q;
	assign mem_bytes    = mem_bytes_q;
	assign is_load      = is_load_q;
	assign is_store     = is_store_q;
	assign next_pc      = next_pc_q;

endmodule

// ===== rtl/core/mde_checker.sv =====
`timescale 1ns / 1ps

`include "mips_decode_execute_unit_macros.svh"

module mde_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         in_ready,
	input  logic         out_valid,
	input  logic         out_ready,
	input  logic [4:0]   op_index,
	input  logic         illegal,
	input  logic [5:0]   src1_reg,
	input  logic [5:0]   src2_reg,
	input  logic [5:0]   dst_reg,
	input  logic [31:0]  result_value,
	input  logic [2:0]   mem_bytes,
	input  logic         is_load,
	input  logic         is_store,
	input  logic [31:0]  next_pc
);

	// An accepted item always leaves the output side occupied.
	`MDE_ASSERT_NEXT(a_accept_fills_out, clk, arst_n, in_valid && in_ready, ##1 out_valid, "accepted item did not reach output")

	// A stalled result holds.
	`MDE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(next_pc) && $stable(op_index), "stalled result changed")

	// Unknown encodings carry no register or memory effect.
	`MDE_ASSERT_SAME(a_illegal_clean, clk, arst_n, out_valid && illegal, op_index == mde_pkg::OP_UNKNOWN && src1_reg == mde_pkg::NO_REG && src2_reg == mde_pkg::NO_REG && dst_reg == mde_pkg::NO_REG && mem_bytes == 3'd0 && !is_load && !is_store && result_value == 32'd0, "illegal item has side effects")

	// A memory access is a load or a store, never both, and has a size.
	`MDE_ASSERT_SAME(a_mem_kind, clk, arst_n, out_valid && (is_load || is_store), !(is_load && is_store) && mem_bytes != 3'd0 && !illegal, "inconsistent memory access")

endmodule

bind mips_decode_execute_unit mde_checker u_checker (.*);
